/* sv/hmc_pkg.sv */
`timescale 1ns / 1ps

package hmc_pkg;

   localparam int LANES     = 8;
   localparam int MAX_WIDTH = 16;
   localparam int PIX_W     = 8;
   localparam int ROW_DEPTH = MAX_WIDTH + 1;
   localparam int ROW_IDX_W = $clog2(ROW_DEPTH);
   localparam bit WIDE_OK   = (MAX_WIDTH >= 2 * LANES);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;
   localparam int HEIGHT_W   = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_AVG_MODE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_X       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_Y       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_BLOCK   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_HEIGHT = CSR_IDX_W'(4);

   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(1);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(16);

   typedef struct packed {
      logic [LANES*PIX_W-1:0] ref_pixels;
      logic [PIX_W-1:0]       ref_extra_pixel;
      logic [LANES*PIX_W-1:0] dest_pixels;
      logic                   chunk_index;
      logic                   priming_row;
   } req_type;

   typedef struct packed {
      logic [LANES*PIX_W-1:0] pred_pixels;
      logic                   out_chunk;
      logic                   last_of_block;
   } rsp_type;

   typedef struct packed {
      logic avg_mode;
      logic half_x;
      logic half_y;
   } lane_mode_type;

endpackage

/* sv/hmc_lane.sv */
`timescale 1ns / 1ps

module hmc_lane
   import hmc_pkg::*;
(
   input  lane_mode_type    mode,
   input  logic [PIX_W-1:0] cur_pix,
   input  logic [PIX_W-1:0] right_pix,
   input  logic [PIX_W-1:0] above_pix,
   input  logic [PIX_W-1:0] above_right_pix,
   input  logic [PIX_W-1:0] dest_pix,
   output logic [PIX_W-1:0] pred_pix
);

   logic [PIX_W+1:0] sum4;
   logic [PIX_W:0]   sum_h;
   logic [PIX_W:0]   sum_v;
   logic [PIX_W:0]   sum_d;
   logic [PIX_W-1:0] interp;

   always_comb begin
      sum4 = (PIX_W+2)'(cur_pix) + (PIX_W+2)'(right_pix) + (PIX_W+2)'(above_pix)
           + (PIX_W+2)'(above_right_pix) + (PIX_W+2)'(2);
      sum_h = (PIX_W+1)'(cur_pix) + (PIX_W+1)'(right_pix) + (PIX_W+1)'(1);
      sum_v = (PIX_W+1)'(cur_pix) + (PIX_W+1)'(above_pix) + (PIX_W+1)'(1);
      if (mode.half_x && mode.half_y) begin
         interp = sum4[PIX_W+1:2];
      end else if (mode.half_x) begin
         interp = sum_h[PIX_W:1];
      end else if (mode.half_y) begin
         interp = sum_v[PIX_W:1];
      end else begin
         interp = cur_pix;
      end
      sum_d = (PIX_W+1)'(interp) + (PIX_W+1)'(dest_pix) + (PIX_W+1)'(1);
      pred_pix = mode.avg_mode ? sum_d[PIX_W:1] : interp;
   end

endmodule

/* sv/hmc_merge.sv */
`timescale 1ns / 1ps

module hmc_merge
   import hmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [PIX_W-1:0] lane_pix [LANES],
   input  logic             chunk,
   input  logic             last,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload
);

   rsp_type merged;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    pop;

   always_comb begin
      merged.pred_pixels = '0;
      for (int i = 0; i < LANES; i++) begin
         merged.pred_pixels[i*PIX_W +: PIX_W] = lane_pix[i];
      end
      merged.out_chunk     = chunk;
      merged.last_of_block = last;
   end

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = merged;
            main_valid_in = 1'b1;
         end else begin
            // output held by the consumer, park the new result
            skid_in       = merged;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a main entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("result pushed while buffer full");

   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && rsp_stall && !skid_valid_ff && push) |=> skid_valid_ff)
      else $error("result lost while output stalled");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to output");

endmodule

/* sv/halfpel_motion_comp_unit.sv */
`timescale 1ns / 1ps
// responses are registered in the output buffer (in the skid entry while the output is held)
// one request per clock unless req_stall; eight pixel lanes work in parallel on each chunk
// priming-row requests update the stored reference row and give no response
// req_stall rises only when the two-entry output buffer is full
// synchronous reset: config to put/full-pel/16 wide/16 rows, stored row and row count to zero

module halfpel_motion_comp_unit
   import hmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                avg_mode_ff, half_x_ff, half_y_ff, wide_block_ff;
   logic [HEIGHT_W-1:0] block_height_ff;
   logic [PIX_W-1:0]    prev_row_ff [ROW_DEPTH];
   logic [PIX_W-1:0]    prev_row_in [ROW_DEPTH];
   logic [HEIGHT_W-1:0] row_count_ff, row_count_in;

   logic                accept;
   logic                push;
   logic                buf_full;
   logic                wide;
   logic                chunk;
   logic                last;
   logic [ROW_IDX_W-1:0] base;
   logic [HEIGHT_W-1:0] height;
   logic [HEIGHT_W:0]   next_count;
   logic [PIX_W-1:0]    cur [LANES+1];
   logic [PIX_W-1:0]    lane_pix [LANES];
   lane_mode_type       mode;

   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && !req_payload.priming_row;

   assign wide  = wide_block_ff && WIDE_OK;
   assign chunk = wide ? req_payload.chunk_index : 1'b0;
   assign base  = chunk ? ROW_IDX_W'(LANES) : '0;

   assign mode.avg_mode = avg_mode_ff;
   assign mode.half_x   = half_x_ff;
   assign mode.half_y   = half_y_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         cur[i] = req_payload.ref_pixels[i*PIX_W +: PIX_W];
      end
      cur[LANES] = req_payload.ref_extra_pixel;
   end

   generate
      for (genvar g = 0; g < LANES; g++) begin : g_lane
         hmc_lane u_lane (
            .mode            (mode),
            .cur_pix         (cur[g]),
            .right_pix       (cur[g+1]),
            .above_pix       (prev_row_ff[base + ROW_IDX_W'(g)]),
            .above_right_pix (prev_row_ff[base + ROW_IDX_W'(g + 1)]),
            .dest_pix        (req_payload.dest_pixels[g*PIX_W +: PIX_W]),
            .pred_pix        (lane_pix[g])
         );
      end
   endgenerate

   // height 0 acts as one row, anything above 16 as 16
   always_comb begin
      if (block_height_ff == '0) begin
         height = HEIGHT_MIN;
      end else if (block_height_ff > HEIGHT_MAX) begin
         height = HEIGHT_MAX;
      end else begin
         height = block_height_ff;
      end
   end

   always_comb begin
      next_count   = (HEIGHT_W+1)'(row_count_ff) + (HEIGHT_W+1)'(1);
      row_count_in = row_count_ff;
      last         = 1'b0;
      if (chunk == wide) begin
         if (next_count >= (HEIGHT_W+1)'(height)) begin
            last         = 1'b1;
            row_count_in = '0;
         end else begin
            row_count_in = next_count[HEIGHT_W-1:0];
         end
      end
   end

   always_comb begin
      prev_row_in = prev_row_ff;
      for (int j = 0; j <= LANES; j++) begin
         prev_row_in[base + ROW_IDX_W'(j)] = cur[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_mode_ff     <= 1'b0;
         half_x_ff       <= 1'b0;
         half_y_ff       <= 1'b0;
         wide_block_ff   <= 1'b1;
         block_height_ff <= HEIGHT_MAX;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_AVG_MODE: begin
               avg_mode_ff <= csr_wdata[0];
            end
            CSR_HALF_X: begin
               half_x_ff <= csr_wdata[0];
            end
            CSR_HALF_Y: begin
               half_y_ff <= csr_wdata[0];
            end
            CSR_WIDE_BLOCK: begin
               wide_block_ff <= csr_wdata[0];
            end
            CSR_BLOCK_HEIGHT: begin
               block_height_ff <= csr_wdata[HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         for (int k = 0; k < ROW_DEPTH; k++) begin
            prev_row_ff[k] <= '0;
         end
      end else if (accept) begin
         prev_row_ff <= prev_row_in;
         if (!req_payload.priming_row) begin
            row_count_ff <= row_count_in;
         end
      end
   end

   hmc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .lane_pix    (lane_pix),
      .chunk       (chunk),
      .last        (last),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import hmc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int BLOCK_ITEMS = 1300;
   localparam int NOISE_ITEMS = 300;
   localparam int DRAIN_CYCLES = 4;

   typedef enum int {RX_FREE, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_pattern_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block: registers, stored reference row, row counter
   bit                    cfg_avg = 1'b0;
   bit                    cfg_hx = 1'b0;
   bit                    cfg_hy = 1'b0;
   bit                    cfg_wide = 1'b1;
   logic [HEIGHT_W-1:0]   cfg_height = HEIGHT_MAX;
   logic [PIX_W-1:0]      ref_row_mem [0:ROW_DEPTH-1] = '{default: '0};
   int                    row_cnt = 0;

   rsp_type               predicted_chunks [$];
   int                    mismatches = 0;
   int                    requests_sent = 0;
   int                    burst_left = 0;
   int                    cycles = 0;

   halfpel_motion_comp_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int eff_rows();
      if (cfg_height == '0) return 1;
      if (cfg_height > HEIGHT_MAX) return 32'(HEIGHT_MAX);
      return 32'(cfg_height);
   endfunction

   function automatic bit wide_active();
      return cfg_wide && WIDE_OK;
   endfunction

   function automatic void predict_chunk(input req_type r);
      logic [PIX_W-1:0] cur [0:LANES];
      int unsigned      a, b, c, d, p, q;
      int               base;
      bit               chunk;
      rsp_type          e;
      chunk = wide_active() ? r.chunk_index : 1'b0;
      base = chunk ? LANES : 0;
      for (int i = 0; i < LANES; i++) cur[i] = r.ref_pixels[PIX_W*i +: PIX_W];
      cur[LANES] = r.ref_extra_pixel;
      e = '0;
      if (!r.priming_row) begin
         for (int i = 0; i < LANES; i++) begin
            a = 32'(cur[i]);
            b = 32'(cur[i+1]);
            c = 32'(ref_row_mem[base+i]);
            d = 32'(ref_row_mem[base+i+1]);
            if (cfg_hx && cfg_hy) p = (a + b + c + d + 2) >> 2;
            else if (cfg_hx) p = (a + b + 1) >> 1;
            else if (cfg_hy) p = (a + c + 1) >> 1;
            else p = a;
            if (cfg_avg) begin
               q = 32'(r.dest_pixels[PIX_W*i +: PIX_W]);
               p = (p + q + 1) >> 1;
            end
            e.pred_pixels[PIX_W*i +: PIX_W] = p[PIX_W-1:0];
         end
      end
      for (int i = 0; i <= LANES; i++) ref_row_mem[base+i] = cur[i];
      if (r.priming_row) return;
      e.out_chunk = chunk;
      e.last_of_block = 1'b0;
      // row counter only moves on the last chunk of a row
      if (chunk == wide_active()) begin
         if (row_cnt + 1 >= eff_rows()) begin
            e.last_of_block = 1'b1;
            row_cnt = 0;
         end else begin
            row_cnt = row_cnt + 1;
         end
      end
      predicted_chunks.push_back(e);
   endfunction

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      static rx_pattern_type rx_pattern = RX_FREE;
      static int rx_left = 0;
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_chunks.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_payload);
         end else begin
            e = predicted_chunks.pop_front();
            if (rsp_payload.pred_pixels !== e.pred_pixels) begin
               mismatches++;
               $display("%0t: pred_pixels expected %h actual %h", $time,
                        e.pred_pixels, rsp_payload.pred_pixels);
            end
            if (rsp_payload.out_chunk !== e.out_chunk) begin
               mismatches++;
               $display("%0t: out_chunk expected %b actual %b", $time,
                        e.out_chunk, rsp_payload.out_chunk);
            end
            if (rsp_payload.last_of_block !== e.last_of_block) begin
               mismatches++;
               $display("%0t: last_of_block expected %b actual %b", $time,
                        e.last_of_block, rsp_payload.last_of_block);
            end
         end
      end
      if (rx_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 200);
      end else begin
         rx_left--;
      end
      case (rx_pattern)
         RX_FREE:  rsp_stall <= 1'b0;
         RX_COIN:  rsp_stall <= ($urandom_range(0, 1) == 0);
         RX_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:  rsp_stall <= (cycles % 7 < 3);
      endcase
   end

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [LANES*PIX_W-1:0] rand_pixels();
      logic [LANES*PIX_W-1:0] v;
      for (int i = 0; i < LANES; i++) v[PIX_W*i +: PIX_W] = rand_pixel();
      return v;
   endfunction

   function automatic req_type rand_req(input bit chunk, input bit prime);
      req_type r;
      r.ref_pixels = rand_pixels();
      r.ref_extra_pixel = rand_pixel();
      r.dest_pixels = rand_pixels();
      r.chunk_index = chunk;
      r.priming_row = prime;
      return r;
   endfunction

   function automatic req_type mk_req(input logic [63:0] pix, input logic [7:0] extra,
                                      input logic [63:0] dest, input bit chunk,
                                      input bit prime);
      req_type r;
      r.ref_pixels = pix;
      r.ref_extra_pixel = extra;
      r.dest_pixels = dest;
      r.chunk_index = chunk;
      r.priming_row = prime;
      return r;
   endfunction

   // sender bursts: random burst length, random gap, sometimes none
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_req(input req_type r);
      pace();
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_chunk(r);
      requests_sent++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_chunks.size() != 0) @(posedge clock);
   endtask

   // priming rows give no response, so let the pipeline empty as well
   task automatic settle();
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_AVG_MODE:     cfg_avg = val[0];
         CSR_HALF_X:       cfg_hx = val[0];
         CSR_HALF_Y:       cfg_hy = val[0];
         CSR_WIDE_BLOCK:   cfg_wide = val[0];
         CSR_BLOCK_HEIGHT: cfg_height = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one-bit registers get junk in the upper data bits
   task automatic set_mode(input bit avg, input bit hx, input bit hy, input bit wide,
                           input logic [HEIGHT_W-1:0] h);
      write_csr(CSR_AVG_MODE, {4'($urandom_range(0, 15)), avg});
      write_csr(CSR_HALF_X, {4'($urandom_range(0, 15)), hx});
      write_csr(CSR_HALF_Y, {4'($urandom_range(0, 15)), hy});
      write_csr(CSR_WIDE_BLOCK, {4'($urandom_range(0, 15)), wide});
      write_csr(CSR_BLOCK_HEIGHT, h);
   endtask

   task automatic test_directed();
      // reset settings: full-pel put, wide, 16 rows
      send_req(mk_req('1, '1, '0, 1'b0, 1'b0));
      send_req(mk_req('0, '0, '1, 1'b1, 1'b0));
      settle();
      // diagonal with averaging, narrow, height zero acts as one
      set_mode(1'b1, 1'b1, 1'b1, 1'b0, '0);
      write_csr(CSR_IDX_W'(5), '1);
      write_csr(CSR_IDX_W'(6), '0);
      write_csr(CSR_IDX_W'(7), 5'h15);
      send_req(mk_req('1, '1, '0, 1'b1, 1'b1));
      send_req(mk_req('0, '0, '1, 1'b1, 1'b0));
      send_req(mk_req('1, '1, '0, 1'b0, 1'b0));
      send_req(mk_req(64'h00ff00ff00ff00ff, 8'h01, 64'h0102030405060708, 1'b0, 1'b0));
      settle();
      // horizontal put, wide, height above range acts as sixteen
      set_mode(1'b0, 1'b1, 1'b0, 1'b1, 5'd17);
      send_req(mk_req(64'hfeff_feff_feff_feff, 8'hfe, '0, 1'b0, 1'b0));
      send_req(mk_req('1, '0, '0, 1'b1, 1'b1));
      send_req(mk_req(64'h0100_0100_0100_0100, 8'h01, '1, 1'b1, 1'b0));
      settle();
      // vertical, then shrink height mid-block: row counter is kept
      set_mode(1'b0, 1'b0, 1'b1, 1'b1, 5'd3);
      for (int k = 0; k < 4; k++) send_req(rand_req(k[0], 1'b0));
      settle();
      write_csr(CSR_BLOCK_HEIGHT, 5'd2);
      send_req(rand_req(1'b0, 1'b0));
      send_req(rand_req(1'b1, 1'b0));
      settle();
      // horizontal with averaging, chunks out of order
      set_mode(1'b1, 1'b1, 1'b0, 1'b1, HEIGHT_MAX);
      send_req(mk_req('1, '1, '1, 1'b1, 1'b0));
      send_req(mk_req('0, '0, '0, 1'b0, 1'b0));
      settle();
   endtask

   task automatic run_block();
      int nch;
      bit flip;
      nch = wide_active() ? 2 : 1;
      if (cfg_hy || $urandom_range(0, 7) == 0) begin
         for (int k = 0; k < nch; k++) send_req(rand_req(k[0], 1'b1));
      end
      for (int row = 0; row < eff_rows(); row++) begin
         flip = ($urandom_range(0, 7) == 0);
         for (int k = 0; k < nch; k++) begin
            if (nch == 1) send_req(rand_req(1'($urandom_range(0, 1)), 1'b0));
            else send_req(rand_req(k[0] ^ flip, 1'b0));
         end
         if ($urandom_range(0, 40) == 0) wait_results();
      end
   endtask

   function automatic logic [HEIGHT_W-1:0] rand_height();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return HEIGHT_W'($urandom_range(17, 31));
         2: return HEIGHT_MAX;
         3: return HEIGHT_MIN;
         default: return HEIGHT_W'($urandom_range(1, 5));
      endcase
   endfunction

   task automatic test_blocks();
      int stop_at;
      stop_at = requests_sent + BLOCK_ITEMS;
      while (requests_sent < stop_at) begin
         settle();
         set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, rand_height());
         repeat ($urandom_range(1, 4)) run_block();
      end
      settle();
   endtask

   task automatic test_pause();
      set_mode(1'b1, 1'b1, 1'b1, 1'b1, 5'd4);
      run_block();
      // hold the sender off until every response is back, then carry on
      wait_results();
      repeat (10) send_req(rand_req(1'($urandom_range(0, 1)), 1'b0));
      settle();
   endtask

   task automatic test_noise();
      repeat (NOISE_ITEMS / 50) begin
         set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  5'($urandom_range(0, 31)));
         repeat (50) send_req(rand_req(1'($urandom_range(0, 1)),
                                       $urandom_range(0, 3) == 0));
         settle();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pause();
      test_blocks();
      test_noise();
      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && predicted_chunks.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/hmc_pkg.sv
sv/hmc_lane.sv
sv/hmc_merge.sv
sv/halfpel_motion_comp_unit.sv
tb/tb.sv
